// ===== design/srdt_pkg.sv =====
// types and constants shared by the serial reply demux tracker
// no dependencies; used by srdt_front, srdt_engine and the top level
package srdt_pkg;

	localparam int IdWidth = 14;

	// command codes of an input word
	localparam logic [1:0] CMD_RX    = 2'd0;
	localparam logic [1:0] CMD_ISSUE = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_BUTTON  = 3'd0;
	localparam logic [2:0] KIND_ID      = 3'd1;
	localparam logic [2:0] KIND_REPLY   = 3'd2;
	localparam logic [2:0] KIND_TIMEOUT = 3'd3;
	localparam logic [2:0] KIND_FULL    = 3'd4;

	// characters
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_CTRL  = 8'h20;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  rx_byte;
		logic        expect_reply;
		logic [15:0] timeout_ms;
	} in_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [2:0]         button_index;
		logic               pressed;
		logic [IdWidth-1:0] cmd_id;
		logic [7:0]         reply_byte;
		logic               byte_valid;
		logic               last;
	} res_t;

	// class given to a word by the front end
	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_BUTTON,
		CLS_TEXT,
		CLS_EOL,
		CLS_ISSUE,
		CLS_TICK
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic [7:0]  data;
		logic        expect_reply;
		logic [15:0] timeout_ms;
	} ent_t;

endpackage

// ===== design/srdt_front.sv =====
// front end: classifies input words and queues them for the engine
// depends on srdt_pkg
module srdt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  srdt_pkg::in_t  item,
	output logic           q_valid,
	output srdt_pkg::ent_t q_entry,
	input  logic           q_take
);

	srdt_pkg::ent_t ent_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	srdt_pkg::ent_t cls_ent;
	logic           do_push;
	logic           do_pop;

	always_comb begin
		cls_ent.data         = item.rx_byte;
		cls_ent.expect_reply = item.expect_reply;
		cls_ent.timeout_ms   = item.timeout_ms;
		unique case (item.command)
			srdt_pkg::CMD_RX: begin
				if (item.rx_byte == srdt_pkg::CH_LF)
					cls_ent.cls = srdt_pkg::CLS_EOL;
				else if (item.rx_byte == srdt_pkg::CH_CR)
					cls_ent.cls = srdt_pkg::CLS_NONE;
				else if (item.rx_byte < srdt_pkg::CH_CTRL)
					cls_ent.cls = srdt_pkg::CLS_BUTTON;
				else
					cls_ent.cls = srdt_pkg::CLS_TEXT;
			end
			srdt_pkg::CMD_ISSUE: cls_ent.cls = srdt_pkg::CLS_ISSUE;
			srdt_pkg::CMD_TICK:  cls_ent.cls = srdt_pkg::CLS_TICK;
			default:             cls_ent.cls = srdt_pkg::CLS_NONE;
		endcase
	end

	assign full    = cnt_q == 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_entry = ent_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_q] <= cls_ent;
	end

endmodule

// ===== design/srdt_engine.sv =====
// back end: line store, pending table and the sequencer that emits results
// depends on srdt_pkg; fed by srdt_front, drains into the top level output register
module srdt_engine #(
	parameter int LINE_CAPACITY = 64,
	parameter int PENDING_DEPTH = 8,
	parameter int ID_MODULUS    = 10000
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  srdt_pkg::ent_t q_entry,
	output logic           q_take,
	input  logic           out_space,
	output logic           out_load,
	output srdt_pkg::res_t out_word
);

	localparam int LW  = $clog2(LINE_CAPACITY);
	localparam int PW  = $clog2(PENDING_DEPTH);
	localparam int IDW = srdt_pkg::IdWidth;

	typedef enum logic [3:0] {
		S_IDLE, S_BTN, S_PRE, S_HASH, S_TAG, S_SLOT, S_TEXT,
		S_ISS_MATCH, S_ISS_FREE, S_TICK, S_FLUSH
	} state_t;

	typedef enum logic [1:0] {P_SPACE, P_DIGIT, P_SKIP} parse_t;

	state_t         state_q;
	srdt_pkg::ent_t item_q;
	logic           ph_q;
	logic [LW-1:0]  idx_q;
	logic [LW-1:0]  len_q;
	logic [LW-1:0]  start_q;
	logic [LW-1:0]  from_q;
	logic [7:0]     mem [LINE_CAPACITY];
	logic [7:0]     rd_q;
	logic [4:0]     mask_q;
	logic [4:0]     chg_q;
	logic           pre_ok_q;
	parse_t         pst_q;
	logic           neg_q;
	logic           ok_q;
	logic           over_q;
	logic [31:0]    v_q;
	logic           tagged_q;
	logic           found_q;
	logic           first_q;
	logic [PW-1:0]  sc_q;
	logic [PW-1:0]  sel_slot_q;
	logic [IDW-1:0] sel_id_q;
	logic [PW-1:0]  sel_rank_q;
	logic [IDW-1:0] ctr_q;

	logic [PENDING_DEPTH-1:0] pv_q;
	logic [PW:0]              nval_q;
	logic [IDW-1:0]           pid_q   [PENDING_DEPTH];
	logic                     pex_q   [PENDING_DEPTH];
	logic [15:0]              prem_q  [PENDING_DEPTH];
	logic [PW-1:0]            prank_q [PENDING_DEPTH];

	srdt_pkg::res_t hold_q;
	logic           hold_v_q;

	logic           cur_v;
	logic [IDW-1:0] cur_id;
	logic           cur_ex;
	logic [15:0]    cur_rem;
	logic [PW-1:0]  cur_rank;
	logic [IDW-1:0] iid;
	logic [IDW-1:0] ctr_next;
	logic           at_end;
	logic           last_slot;
	logic           can_go;
	logic           emit_req;
	logic           emit_fire;
	logic           flush_fire;
	srdt_pkg::res_t emit_word;
	logic [2:0]     low_bit;
	logic           drop_en;
	logic [PW-1:0]  drop_slot;
	logic [PW-1:0]  drop_rank;
	logic           add_en;
	logic           dec_en;
	logic           hit_tag;
	logic           hit_unt;
	logic           hit;
	logic           is_digit;
	logic [35:0]    acc_next;
	logic           tag_ok;
	logic [7:0]     pre_char;
	logic           text_ok;

	assign cur_v     = pv_q[sc_q];
	assign cur_id    = pid_q[sc_q];
	assign cur_ex    = pex_q[sc_q];
	assign cur_rem   = prem_q[sc_q];
	assign cur_rank  = prank_q[sc_q];
	assign iid       = ctr_q + IDW'(1);
	assign ctr_next  = (iid == IDW'(ID_MODULUS)) ? '0 : iid;
	assign at_end    = idx_q == len_q;
	assign last_slot = sc_q == PW'(PENDING_DEPTH - 1);
	assign can_go    = !hold_v_q || out_space;
	assign q_take    = state_q == S_IDLE && q_valid;
	assign text_ok   = len_q != LW'(LINE_CAPACITY - 1);

	assign is_digit = rd_q >= srdt_pkg::CH_ZERO && rd_q <= srdt_pkg::CH_NINE;
	assign acc_next = ({4'd0, v_q} << 3) + ({4'd0, v_q} << 1)
		+ {28'd0, rd_q - srdt_pkg::CH_ZERO};
	// a value beyond the signed 32-bit range leaves the line untagged
	assign tag_ok   = ok_q && !over_q && !(!neg_q && v_q == 32'h8000_0000);
	assign pre_char = (idx_q == LW'(3)) ? srdt_pkg::CH_SPACE : srdt_pkg::CH_GT;

	assign hit_tag = cur_v && !found_q && v_q[31:IDW] == '0 && cur_id == v_q[IDW-1:0];
	assign hit_unt = cur_v && cur_ex && (!found_q || cur_rank < sel_rank_q);
	assign hit     = tagged_q ? hit_tag : hit_unt;

	always_comb begin
		low_bit = 3'd0;
		for (int i = 4; i >= 0; i--)
			if (chg_q[i])
				low_bit = 3'(i);
	end

	// result produced this cycle, and table updates that go with it
	always_comb begin
		emit_req  = 1'b0;
		emit_word = '0;
		drop_en   = 1'b0;
		drop_slot = sc_q;
		drop_rank = cur_rank;
		add_en    = 1'b0;
		dec_en    = 1'b0;
		unique case (state_q)
			S_BTN: begin
				emit_req               = chg_q != 5'd0;
				emit_word.kind         = srdt_pkg::KIND_BUTTON;
				emit_word.button_index = low_bit;
				emit_word.pressed      = mask_q[low_bit];
			end
			S_ISS_MATCH: drop_en = cur_v && cur_id == iid;
			S_ISS_FREE: begin
				emit_req = !cur_v || last_slot;
				if (!cur_v) begin
					emit_word.kind   = srdt_pkg::KIND_ID;
					emit_word.cmd_id = iid;
					add_en           = can_go;
				end else begin
					emit_word.kind = srdt_pkg::KIND_FULL;
				end
			end
			S_TICK: begin
				emit_req         = cur_v && cur_rem == 16'd0;
				emit_word.kind   = srdt_pkg::KIND_TIMEOUT;
				emit_word.cmd_id = cur_id;
				drop_en          = emit_req && can_go;
				dec_en           = cur_v && cur_rem != 16'd0;
			end
			S_TEXT: begin
				emit_word.kind   = srdt_pkg::KIND_REPLY;
				emit_word.cmd_id = sel_id_q;
				drop_slot        = sel_slot_q;
				drop_rank        = sel_rank_q;
				if (at_end) begin
					emit_req = first_q;
					drop_en  = !first_q || can_go;
				end else begin
					emit_req             = ph_q;
					emit_word.reply_byte = rd_q;
					emit_word.byte_valid = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign emit_fire  = emit_req && can_go;
	assign flush_fire = state_q == S_FLUSH && hold_v_q && out_space;
	assign out_load   = (emit_fire && hold_v_q) || flush_fire;
	always_comb begin
		out_word      = hold_q;
		out_word.last = state_q == S_FLUSH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			hold_v_q <= 1'b0;
			mask_q   <= '0;
			len_q    <= '0;
			pv_q     <= '0;
			nval_q   <= '0;
			ctr_q    <= '0;
			ph_q     <= 1'b0;
		end else begin
			if (emit_fire)
				hold_v_q <= 1'b1;
			if (drop_en) begin
				pv_q[drop_slot] <= 1'b0;
				nval_q          <= nval_q - (PW+1)'(1);
			end
			if (add_en) begin
				pv_q[sc_q] <= 1'b1;
				nval_q     <= nval_q + (PW+1)'(1);
				ctr_q      <= ctr_next;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						item_q <= q_entry;
						unique case (q_entry.cls)
							srdt_pkg::CLS_BUTTON: begin
								chg_q   <= q_entry.data[4:0] ^ mask_q;
								mask_q  <= q_entry.data[4:0];
								state_q <= S_BTN;
							end
							srdt_pkg::CLS_TEXT: begin
								// overflow throws the whole line away
								if (text_ok)
									len_q <= len_q + LW'(1);
								else
									len_q <= '0;
							end
							srdt_pkg::CLS_EOL: begin
								idx_q    <= '0;
								ph_q     <= 1'b0;
								pre_ok_q <= 1'b1;
								start_q  <= '0;
								if (len_q >= LW'(4))
									state_q <= S_PRE;
								else if (len_q != '0)
									state_q <= S_HASH;
							end
							srdt_pkg::CLS_ISSUE: begin
								sc_q    <= '0;
								state_q <= S_ISS_MATCH;
							end
							srdt_pkg::CLS_TICK: begin
								sc_q    <= '0;
								state_q <= S_TICK;
							end
							default: ;
						endcase
					end
				end
				S_BTN: begin
					if (chg_q == 5'd0)
						state_q <= S_FLUSH;
					else if (can_go)
						chg_q[low_bit] <= 1'b0;
				end
				S_PRE: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (rd_q != pre_char)
							pre_ok_q <= 1'b0;
						if (idx_q == LW'(3)) begin
							if (pre_ok_q && rd_q == pre_char) begin
								start_q <= LW'(4);
								idx_q   <= LW'(4);
							end else begin
								idx_q <= '0;
							end
							state_q <= S_HASH;
						end else begin
							idx_q <= idx_q + LW'(1);
						end
					end
				end
				S_HASH: begin
					if (at_end) begin
						tagged_q <= 1'b0;
						from_q   <= start_q;
						found_q  <= 1'b0;
						sc_q     <= '0;
						state_q  <= S_SLOT;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							idx_q <= idx_q + LW'(1);
							if (rd_q == srdt_pkg::CH_HASH) begin
								pst_q   <= P_SPACE;
								neg_q   <= 1'b0;
								ok_q    <= 1'b0;
								over_q  <= 1'b0;
								v_q     <= '0;
								state_q <= S_TAG;
							end
						end
					end
				end
				S_TAG: begin
					if (at_end) begin
						// no colon: untagged
						tagged_q <= 1'b0;
						from_q   <= start_q;
						found_q  <= 1'b0;
						sc_q     <= '0;
						state_q  <= S_SLOT;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							idx_q <= idx_q + LW'(1);
							if (rd_q == srdt_pkg::CH_COLON) begin
								found_q <= 1'b0;
								sc_q    <= '0;
								if (tag_ok) begin
									tagged_q <= 1'b1;
									from_q   <= idx_q + LW'(1);
									// negative or zero ids name nothing
									if (neg_q || v_q == '0)
										state_q <= S_FLUSH;
									else
										state_q <= S_SLOT;
								end else begin
									tagged_q <= 1'b0;
									from_q   <= start_q;
									state_q  <= S_SLOT;
								end
							end else begin
								unique case (pst_q)
									P_SPACE: begin
										if (rd_q == srdt_pkg::CH_PLUS ||
											rd_q == srdt_pkg::CH_MINUS) begin
											neg_q <= rd_q == srdt_pkg::CH_MINUS;
											pst_q <= P_DIGIT;
										end else if (is_digit) begin
											ok_q  <= 1'b1;
											pst_q <= P_DIGIT;
											v_q   <= acc_next[31:0];
										end else if (rd_q != srdt_pkg::CH_SPACE) begin
											pst_q <= P_SKIP;
										end
									end
									P_DIGIT: begin
										if (is_digit) begin
											ok_q <= 1'b1;
											if (!over_q) begin
												if (acc_next > 36'h0_8000_0000)
													over_q <= 1'b1;
												else
													v_q <= acc_next[31:0];
											end
										end else begin
											pst_q <= P_SKIP;
										end
									end
									default: ;
								endcase
							end
						end
					end
				end
				S_SLOT: begin
					if (hit) begin
						found_q    <= 1'b1;
						sel_slot_q <= sc_q;
						sel_id_q   <= cur_id;
						sel_rank_q <= cur_rank;
					end
					if (last_slot) begin
						idx_q   <= from_q;
						ph_q    <= 1'b0;
						first_q <= 1'b1;
						state_q <= (found_q || hit) ? S_TEXT : S_FLUSH;
					end else begin
						sc_q <= sc_q + PW'(1);
					end
				end
				S_TEXT: begin
					if (at_end) begin
						if (drop_en)
							state_q <= S_FLUSH;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (can_go) begin
						idx_q   <= idx_q + LW'(1);
						ph_q    <= 1'b0;
						first_q <= 1'b0;
					end
				end
				S_ISS_MATCH: begin
					if (drop_en || last_slot) begin
						sc_q    <= '0;
						state_q <= S_ISS_FREE;
					end else begin
						sc_q <= sc_q + PW'(1);
					end
				end
				S_ISS_FREE: begin
					if (emit_req) begin
						if (can_go)
							state_q <= S_FLUSH;
					end else begin
						sc_q <= sc_q + PW'(1);
					end
				end
				S_TICK: begin
					if (!(emit_req && !can_go)) begin
						if (last_slot)
							state_q <= S_FLUSH;
						else
							sc_q <= sc_q + PW'(1);
					end
				end
				S_FLUSH: begin
					if (!hold_v_q || out_space) begin
						hold_v_q <= 1'b0;
						state_q  <= S_IDLE;
						if (item_q.cls == srdt_pkg::CLS_EOL)
							len_q <= '0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// line store, read one address a cycle
	always_ff @(posedge clk) begin
		if (q_take && q_entry.cls == srdt_pkg::CLS_TEXT && text_ok)
			mem[len_q] <= q_entry.data;
		rd_q <= mem[idx_q];
	end

	// pending table payload and held result
	always_ff @(posedge clk) begin
		if (emit_fire)
			hold_q <= emit_word;
		if (add_en) begin
			pid_q[sc_q]   <= iid;
			pex_q[sc_q]   <= item_q.expect_reply;
			prem_q[sc_q]  <= item_q.timeout_ms;
			prank_q[sc_q] <= nval_q[PW-1:0];
		end
		if (dec_en)
			prem_q[sc_q] <= cur_rem - 16'd1;
		if (drop_en)
			for (int i = 0; i < PENDING_DEPTH; i++)
				if (pv_q[i] && prank_q[i] > drop_rank)
					prank_q[i] <= prank_q[i] - PW'(1);
	end

`ifndef NO_ASSERTIONS
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		nval_q == (PW+1)'($countones(pv_q)))
		else $error("pending count out of step with valid bits");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !hold_v_q)
		else $error("held result left behind at idle");
	a_load_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_space)
		else $error("result loaded into a full output register");
	a_no_drop_add: assert property (@(posedge clk) disable iff (!arst_n)
		!(drop_en && add_en))
		else $error("entry dropped and added in one cycle");
`endif

endmodule

// ===== design/serial_reply_demux_tracker_top.sv =====
// top level of the serial reply demux tracker: front queue, engine, output register
// depends on srdt_pkg, srdt_front and srdt_engine
//
// serial reply demux tracker. words go in through push/full and results come
// out through empty/pop, both in queue style. a word is a received byte, a
// command issue or a 1 ms tick. control bytes below 0x20 (other than cr/lf)
// are a 5-bit button mask, and each changed bit gives one result. other bytes
// build a line; lf routes it to the pending command named by a "#id:" tag, or
// to the oldest one that expects a reply, one result per reply character.
// issue assigns ids 1..ID_MODULUS in turn; ticks age and expire commands.
// the final result of each word carries last. a front queue of two words lets
// the source run ahead while the engine works. the engine takes each word in
// steps: a button word emits its changes one at a time; an issue and a tick
// scan the pending table one slot at a time; a line end is parsed from the
// one-port line store, then the table is scanned, then the reply characters
// are read out one by one.
// results leave through one output register, so a stalled pop stalls the
// engine but not the front queue.
module serial_reply_demux_tracker_top #(
	parameter int LINE_CAPACITY = 64,
	parameter int PENDING_DEPTH = 8,
	parameter int ID_MODULUS    = 10000
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  srdt_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output srdt_pkg::res_t result
);

	// front queue to engine
	logic           q_valid;
	srdt_pkg::ent_t q_entry;
	logic           q_take;

	// engine to output register
	logic           out_space;
	logic           out_load;
	srdt_pkg::res_t out_word;

	// output register
	logic           out_v_q;
	srdt_pkg::res_t out_q;

	srdt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_take  (q_take)
	);

	srdt_engine #(
		.LINE_CAPACITY (LINE_CAPACITY),
		.PENDING_DEPTH (PENDING_DEPTH),
		.ID_MODULUS    (ID_MODULUS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_take    (q_take),
		.out_space (out_space),
		.out_load  (out_load),
		.out_word  (out_word)
	);

	// room when empty or when the waiting word goes this cycle
	assign out_space = !out_v_q || pop;
	assign empty     = !out_v_q;
	assign result    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else begin
			if (out_load)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= out_word;
	end

endmodule

// ===== bench/tb.sv =====
// testbench for serial_reply_demux_tracker_top: directed tests then random traffic
// depends on srdt_pkg and the top level; self-checking against an internal predictor
`timescale 1ns / 100ps

module tb;

	localparam int LineCap   = 64;
	localparam int PendDepth = 8;
	localparam int IdMod     = 10000;
	localparam int WatchLimit = 200000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	srdt_pkg::in_t  item;
	logic empty;
	logic pop;
	srdt_pkg::res_t result;

	serial_reply_demux_tracker_top u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	// clock, 10 ns period
	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// predictor state, a mirror of the block
	logic [4:0]  mask_q;
	logic [7:0]  line_q [LineCap];
	int          len_q;
	logic        pv [PendDepth];
	logic [13:0] pid [PendDepth];
	logic        pexp [PendDepth];
	logic [15:0] prem [PendDepth];
	int          prank [PendDepth];
	int          id_cnt;

	srdt_pkg::res_t expected_results [$];
	int   fail_count = 0;
	int   got_count = 0;
	int   idle_cycles = 0;
	bit   hold_pop = 0;
	bit   pop_gaps = 1;

	task automatic report(input string what, input srdt_pkg::res_t got,
			input srdt_pkg::res_t exp);
		$display("mismatch %s: got %h expected %h", what, got, exp);
		fail_count++;
	endtask

	function automatic void add_result(input logic [2:0] k, input int idx, input bit pr,
			input int id, input logic [7:0] b, input bit v);
		srdt_pkg::res_t r;
		r = '0;
		r.kind = k; r.button_index = idx[2:0]; r.pressed = pr;
		r.cmd_id = id[13:0]; r.reply_byte = b; r.byte_valid = v;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void drop_slot(input int s);
		pv[s] = 0;
		for (int i = 0; i < PendDepth; i++)
			if (pv[i] && prank[i] > prank[s])
				prank[i]--;
	endfunction

	function automatic void emit_reply(input int s, input int from, input int upto);
		if (from >= upto)
			add_result(srdt_pkg::KIND_REPLY, 0, 0, pid[s], 8'h00, 0);
		else
			for (int i = from; i < upto; i++)
				add_result(srdt_pkg::KIND_REPLY, 0, 0, pid[s], line_q[i], 1);
		drop_slot(s);
	endfunction

	function automatic void route_reply();
		int start, hash, colon, p, best;
		bit neg, ok;
		longint unsigned v;
		start = 0; hash = -1; colon = -1; best = -1;
		if (len_q >= 4 && line_q[0] == srdt_pkg::CH_GT && line_q[1] == srdt_pkg::CH_GT &&
				line_q[2] == srdt_pkg::CH_GT && line_q[3] == srdt_pkg::CH_SPACE)
			start = 4;
		for (int i = start; i < len_q; i++)
			if (line_q[i] == srdt_pkg::CH_HASH) begin
				hash = i;
				break;
			end
		if (hash >= 0)
			for (int i = hash + 1; i < len_q; i++)
				if (line_q[i] == srdt_pkg::CH_COLON) begin
					colon = i;
					break;
				end
		if (colon >= 0) begin
			p = hash + 1; neg = 0; ok = 0; v = 0;
			while (p < colon && line_q[p] == srdt_pkg::CH_SPACE)
				p++;
			if (p < colon && (line_q[p] == srdt_pkg::CH_PLUS ||
					line_q[p] == srdt_pkg::CH_MINUS)) begin
				neg = line_q[p] == srdt_pkg::CH_MINUS;
				p++;
			end
			while (p < colon && line_q[p] >= srdt_pkg::CH_ZERO &&
					line_q[p] <= srdt_pkg::CH_NINE) begin
				ok = 1;
				if (v <= 64'h8000_0000)
					v = v * 10 + (line_q[p] - srdt_pkg::CH_ZERO);
				p++;
			end
			// a tag in signed 32-bit range consumes the line
			if (ok && v <= (neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
				if (neg || v == 0)
					return;
				for (int s = 0; s < PendDepth; s++)
					if (pv[s] && pid[s] == v) begin
						emit_reply(s, colon + 1, len_q);
						return;
					end
				return;
			end
		end
		for (int s = 0; s < PendDepth; s++)
			if (pv[s] && pexp[s] && (best < 0 || prank[s] < prank[best]))
				best = s;
		if (best >= 0)
			emit_reply(best, start, len_q);
	endfunction

	function automatic void predict_word(input srdt_pkg::in_t w);
		int n_prior, slot, count, nid;
		logic [4:0] chg;
		n_prior = expected_results.size();
		if (w.command == srdt_pkg::CMD_RX) begin
			if (w.rx_byte < srdt_pkg::CH_CTRL && w.rx_byte != srdt_pkg::CH_CR &&
					w.rx_byte != srdt_pkg::CH_LF) begin
				chg = w.rx_byte[4:0] ^ mask_q;
				mask_q = w.rx_byte[4:0];
				for (int b = 0; b < 5; b++)
					if (chg[b])
						add_result(srdt_pkg::KIND_BUTTON, b, w.rx_byte[b], 0, 8'h00, 0);
			end else if (w.rx_byte == srdt_pkg::CH_LF) begin
				if (len_q > 0) begin
					route_reply();
					len_q = 0;
				end
			end else if (w.rx_byte != srdt_pkg::CH_CR) begin
				if (len_q < LineCap - 1)
					line_q[len_q++] = w.rx_byte;
				else
					len_q = 0;
			end
		end else if (w.command == srdt_pkg::CMD_ISSUE) begin
			nid = (id_cnt % IdMod) + 1;
			slot = -1; count = 0;
			for (int s = 0; s < PendDepth; s++)
				if (pv[s] && pid[s] == nid) begin
					drop_slot(s);
					break;
				end
			for (int s = 0; s < PendDepth; s++)
				if (pv[s]) count++;
				else if (slot < 0) slot = s;
			if (slot < 0)
				add_result(srdt_pkg::KIND_FULL, 0, 0, 0, 8'h00, 0);
			else begin
				id_cnt = (id_cnt + 1) % IdMod;
				pv[slot] = 1; pid[slot] = 14'(nid); pexp[slot] = w.expect_reply;
				prem[slot] = w.timeout_ms; prank[slot] = count;
				add_result(srdt_pkg::KIND_ID, 0, 0, nid, 8'h00, 0);
			end
		end else if (w.command == srdt_pkg::CMD_TICK) begin
			for (int s = 0; s < PendDepth; s++) begin
				if (!pv[s])
					continue;
				if (prem[s] == 0) begin
					add_result(srdt_pkg::KIND_TIMEOUT, 0, 0, pid[s], 8'h00, 0);
					drop_slot(s);
				end else
					prem[s]--;
			end
		end
		if (expected_results.size() > n_prior)
			expected_results[expected_results.size() - 1].last = 1'b1;
	endfunction

	// send one word: random gap, then hold push until accepted
	task automatic send_word(input srdt_pkg::in_t w, input bit gaps = 1);
		int gap;
		gap = gaps ? $urandom_range(0, 17) : 0;
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) begin
			push <= 1'b0;
			item <= srdt_pkg::in_t'($urandom);
			@(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_word(w);
	endtask

	task automatic send_rx(input logic [7:0] b, input bit gaps = 1);
		srdt_pkg::in_t w;
		w = srdt_pkg::in_t'($urandom);
		w.command = srdt_pkg::CMD_RX;
		w.rx_byte = b;
		send_word(w, gaps);
	endtask

	task automatic send_issue(input bit er, input logic [15:0] tmo, input bit gaps = 1);
		srdt_pkg::in_t w;
		w = srdt_pkg::in_t'($urandom);
		w.command = srdt_pkg::CMD_ISSUE;
		w.expect_reply = er;
		w.timeout_ms = tmo;
		send_word(w, gaps);
	endtask

	task automatic send_tick();
		srdt_pkg::in_t w;
		w = srdt_pkg::in_t'($urandom);
		w.command = srdt_pkg::CMD_TICK;
		send_word(w);
	endtask

	task automatic send_text(input string s, input bit gaps = 1);
		for (int i = 0; i < s.len(); i++)
			send_rx(s[i], gaps);
	endtask

	// result checker: pop with random stalls, compare against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		int wait_left;
		if (!arst_n) begin
			pop <= 1'b0;
			wait_left = 0;
		end else begin
			if (pop && !empty) begin
				got_count++;
				if (expected_results.size() == 0) begin
					report("unexpected", result, '0);
				end else begin
					srdt_pkg::res_t e;
					e = expected_results.pop_front();
					if (result.kind != e.kind) report("kind", result, e);
					if (result.button_index != e.button_index) report("button", result, e);
					if (result.pressed != e.pressed) report("pressed", result, e);
					if (result.cmd_id != e.cmd_id) report("cmd_id", result, e);
					if (result.reply_byte != e.reply_byte) report("byte", result, e);
					if (result.byte_valid != e.byte_valid) report("valid", result, e);
					if (result.last != e.last) report("last", result, e);
				end
				wait_left = pop_gaps ? $urandom_range(0, 17) : 0;
				if ($urandom_range(0, 3) == 0) wait_left = 0;
			end
			if (hold_pop)
				pop <= 1'b0;
			else if (wait_left > 0) begin
				wait_left--;
				pop <= 1'b0;
			end else
				pop <= 1'b1;
		end
	end

	// watchdog: cycles with no accepted word on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic test_buttons();
		send_rx(8'h1F);            // all five bits pressed
		send_rx(8'h1F);            // unchanged mask, nothing out
		send_rx(8'h00);            // all released
		send_rx(8'h15);
		send_rx(8'h0D);            // lone cr, dropped
		send_rx(8'h0A);            // lf on empty line does nothing
	endtask

	task automatic test_replies();
		send_issue(1'b1, 16'hFFFF);
		send_issue(1'b0, 16'd3);
		send_text(">>> hi\r\n");       // prompt stripped, oldest waiter
		send_text("#2:ok\n");          // tagged reply to id 2
		send_text("#7:x\n");           // unknown tag, consumed
		send_issue(1'b1, 16'd0);
		send_text("#3:\n");            // matched, empty reply
		send_text("none\n");           // no waiter
		send_text("# +x:z\n");         // bad tag, untagged path
	endtask

	task automatic test_expiry_and_full();
		for (int i = 0; i < PendDepth + 1; i++)
			send_issue(i[0], 16'd1);
		send_tick();
		send_tick();
		send_tick();
	endtask

	task automatic test_overflow();
		for (int i = 0; i < LineCap; i++)
			send_rx(8'(8'h61 + (i % 26)), 0);
		send_text("ab\n");
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		hold_pop = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_pop = 0;
			end
			begin
				for (int i = 0; i < 12; i++)
					send_rx(i[0] ? 8'h1F : 8'h00, 0);
				push <= 1'b0;
				@(posedge clk);
			end
		join
	endtask

	function automatic string rand_line();
		string s, d;
		int m;
		s = "";
		m = $urandom_range(0, 5);
		if (m == 0) s = ">>> ";
		if (m <= 2) begin
			d.itoa($urandom_range(0, 3) == 0 ? $urandom_range(0, 99999) :
				(id_cnt + IdMod - $urandom_range(0, 9)) % IdMod + 1);
			s = {s, "#", ($urandom_range(0, 3) == 0) ? " " : "", d, ":"};
		end
		for (int i = $urandom_range(0, 8); i > 0; i--)
			s = {s, string'(8'($urandom_range(33, 126)))};
		return {s, "\n"};
	endfunction

	task automatic test_random();
		int sent, r;
		string s;
		srdt_pkg::in_t w;
		sent = 0;
		while (sent < 95) begin
			r = $urandom_range(0, 9);
			if (r < 3) begin
				s = rand_line();
				send_text(s);
				sent += s.len();
			end else if (r < 5) begin
				send_issue(1'($urandom), 16'($urandom_range(0, 3) == 0 ? $urandom :
					$urandom_range(0, 6)));
				sent++;
			end else if (r < 7) begin
				send_tick();
				sent++;
			end else if (r < 8) begin
				send_rx(8'($urandom_range(0, 31)));
				sent++;
			end else begin
				w = srdt_pkg::in_t'($urandom);
				if (w.command == srdt_pkg::CMD_RX && w.rx_byte == srdt_pkg::CH_LF)
					w.rx_byte = srdt_pkg::CH_CR;
				send_word(w);
				sent++;
			end
		end
	endtask

	initial begin
		int tail;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		mask_q = '0; len_q = 0; id_cnt = 0;
		for (int s = 0; s < PendDepth; s++) begin
			pv[s] = 0; prank[s] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_buttons();
		test_replies();
		test_expiry_and_full();
		test_overflow();
		test_backpressure();
		test_random();
		push <= 1'b0;

		// drain, then a short tail for stray results
		while (expected_results.size() != 0)
			@(posedge clk);
		tail = 0;
		while (tail < 400) begin
			@(posedge clk);
			tail++;
		end
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
